// ===== hw/rtl/can_sensor_frame_decoder_averager_top_defines.svh =====
// assertion macros for the sensor frame decoder
`ifndef CAN_SENSOR_FRAME_DECODER_AVERAGER_TOP_DEFINES_SVH
`define CAN_SENSOR_FRAME_DECODER_AVERAGER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CSFDA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// next-cycle implication
`define CSFDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CSFDA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CSFDA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/csfda_pkg.sv =====
package csfda_pkg;

   localparam int ID_W    = 11;
   localparam int MUX_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 32;
   localparam int CNT_W   = 16;
   localparam int SUM_W   = 64;

   localparam logic [ID_W-1:0] ID_BASE_RESET = 11'd1377;

   // measurement kinds, offset from the base id and matching mux byte
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_CURRENT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_VOLT1   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VOLT2   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_VOLT3   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TEMP    = 3'd4;

   // divider retires this many quotient bits per cycle
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS      = SUM_W / DIV_RADIX_BITS;
   localparam int STEP_W         = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load_frame;
      logic load_poll;
      logic div_step;
      logic div_done;
   } csfda_cmd_type;

   typedef struct packed {
      logic count_zero;
   } csfda_status_type;

endpackage

// ===== hw/rtl/csfda_ctrl.sv =====
module csfda_ctrl
   import csfda_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_action,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  csfda_status_type status,
   output csfda_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [STEP_W-1:0] step_ff;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load_frame = accept && !req_action;
   assign cmd.load_poll  = accept && req_action;
   assign cmd.div_step   = (state_ff == ST_DIVIDE);
   assign cmd.div_done   = (state_ff == ST_FINISH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_action && !status.count_zero) begin
                     state_ff     <= ST_DIVIDE;
                     step_ff      <= '0;
                     rsp_valid_ff <= 1'b0;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_LAST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/csfda_datapath.sv =====
module csfda_datapath
   import csfda_pkg::*;
#(
   parameter int COUNT_MAX = 65535
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ID_W-1:0]           csr_wr_data,
   input  logic [ID_W-1:0]           req_frame_id,
   input  logic [MUX_W-1:0]          req_mux_byte,
   input  logic [BYTE_W-1:0]         req_value_byte_hi,
   input  logic [BYTE_W-1:0]         req_value_byte_mid_hi,
   input  logic [BYTE_W-1:0]         req_value_byte_mid_lo,
   input  logic [BYTE_W-1:0]         req_value_byte_lo,
   input  csfda_cmd_type             cmd,
   output csfda_status_type          status,
   output logic                      rsp_frame_accepted,
   output logic                      rsp_average_valid,
   output logic signed [VALUE_W-1:0] rsp_average_current,
   output logic signed [VALUE_W-1:0] rsp_latest_current,
   output logic signed [VALUE_W-1:0] rsp_voltage_one,
   output logic signed [VALUE_W-1:0] rsp_voltage_two,
   output logic signed [VALUE_W-1:0] rsp_voltage_three,
   output logic signed [VALUE_W-1:0] rsp_temperature_reading
);

   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(COUNT_MAX);

   // architectural state
   logic [ID_W-1:0]    id_base_ff;
   logic [VALUE_W-1:0] last_current_ff;
   logic [VALUE_W-1:0] volt_ff [3];
   logic [VALUE_W-1:0] temp_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   count_ff;

   // divider
   logic [SUM_W-1:0]   quot_ff;
   logic [SUM_W-1:0]   quot_in;
   logic [CNT_W-1:0]   rem_ff;
   logic [CNT_W-1:0]   rem_in;
   logic [CNT_W-1:0]   divisor_ff;
   logic               neg_ff;

   // result register
   logic               accepted_ff;
   logic               avg_valid_ff;
   logic [VALUE_W-1:0] avg_ff;

   logic [VALUE_W-1:0] value;
   logic [ID_W-1:0]    kind_diff;
   logic [KIND_W-1:0]  kind;
   logic               hit;
   logic [SUM_W-1:0]   sum_mag;
   logic [VALUE_W-1:0] mean_mag;
   logic [VALUE_W-1:0] mean;

   assign value = {req_value_byte_hi, req_value_byte_mid_hi,
                   req_value_byte_mid_lo, req_value_byte_lo};

   // frame id must sit in the five ids from the base, mux byte must match
   assign kind_diff = req_frame_id - id_base_ff;
   assign kind      = kind_diff[KIND_W-1:0];
   assign hit       = (req_frame_id >= id_base_ff) &&
                      (kind_diff <= ID_W'(KIND_TEMP)) &&
                      (req_mux_byte == MUX_W'(kind));

   assign sum_mag  = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
   assign mean_mag = quot_ff[VALUE_W-1:0];
   assign mean     = neg_ff ? (VALUE_W'(0) - mean_mag) : mean_mag;

   assign status.count_zero = (count_ff == '0);

   // restoring division, DIV_RADIX_BITS quotient bits per step
   always_comb begin
      logic [CNT_W:0]   part;
      logic [CNT_W-1:0] rem;
      logic [SUM_W-1:0] quot;
      rem  = rem_ff;
      quot = quot_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         part = {rem, quot[SUM_W-1]};
         quot = {quot[SUM_W-2:0], 1'b0};
         if (part >= {1'b0, divisor_ff}) begin
            part    = part - {1'b0, divisor_ff};
            quot[0] = 1'b1;
         end
         rem = part[CNT_W-1:0];
      end
      quot_in = quot;
      rem_in  = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff      <= ID_BASE_RESET;
         last_current_ff <= '0;
         volt_ff[0]      <= '0;
         volt_ff[1]      <= '0;
         volt_ff[2]      <= '0;
         temp_ff         <= '0;
         sum_ff          <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_wr_en) begin
            id_base_ff <= csr_wr_data;
         end
         if (cmd.load_frame && hit) begin
            case (kind)
               KIND_CURRENT: begin
                  last_current_ff <= value;
                  if (count_ff < COUNT_LIMIT) begin
                     sum_ff   <= sum_ff + {{(SUM_W - VALUE_W){value[VALUE_W-1]}}, value};
                     count_ff <= count_ff + 1'b1;
                  end
               end
               KIND_VOLT1: volt_ff[0] <= value;
               KIND_VOLT2: volt_ff[1] <= value;
               KIND_VOLT3: volt_ff[2] <= value;
               KIND_TEMP:  temp_ff    <= value;
               default: begin
               end
            endcase
         end
         if (cmd.load_poll) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_poll) begin
         quot_ff    <= sum_mag;
         rem_ff     <= '0;
         divisor_ff <= count_ff;
         neg_ff     <= sum_ff[SUM_W-1];
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_frame) begin
         accepted_ff  <= hit;
         avg_valid_ff <= 1'b0;
         avg_ff       <= '0;
      end else if (cmd.load_poll) begin
         accepted_ff  <= 1'b0;
         avg_valid_ff <= 1'b1;
         avg_ff       <= last_current_ff;
      end else if (cmd.div_done) begin
         avg_ff <= mean;
      end
   end

   assign rsp_frame_accepted      = accepted_ff;
   assign rsp_average_valid       = avg_valid_ff;
   assign rsp_average_current     = avg_ff;
   assign rsp_latest_current      = last_current_ff;
   assign rsp_voltage_one         = volt_ff[0];
   assign rsp_voltage_two         = volt_ff[1];
   assign rsp_voltage_three       = volt_ff[2];
   assign rsp_temperature_reading = temp_ff;

endmodule

// ===== hw/rtl/can_sensor_frame_decoder_averager_top.sv =====
// a frame or a poll with no samples gives its result in the cycle after the transfer
// a poll with samples steps the 64-by-16 divider (2 bits/cycle), then gives its result
// throughput: one frame per cycle if rsp_ready is high; a dividing poll stalls the input
// one result at a time: a new request is taken when the result register is empty or drains
// reset: synchronous, active high; clears all readings, sum, count and sets id_base to 0x561
`include "can_sensor_frame_decoder_averager_top_defines.svh"

module can_sensor_frame_decoder_averager_top
   import csfda_pkg::*;
#(
   parameter int COUNT_MAX = 65535
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [ID_W-1:0]           csr_wr_data,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_action,
   input  logic [ID_W-1:0]           req_frame_id,
   input  logic [MUX_W-1:0]          req_mux_byte,
   input  logic [BYTE_W-1:0]         req_value_byte_hi,
   input  logic [BYTE_W-1:0]         req_value_byte_mid_hi,
   input  logic [BYTE_W-1:0]         req_value_byte_mid_lo,
   input  logic [BYTE_W-1:0]         req_value_byte_lo,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_frame_accepted,
   output logic                      rsp_average_valid,
   output logic signed [VALUE_W-1:0] rsp_average_current,
   output logic signed [VALUE_W-1:0] rsp_latest_current,
   output logic signed [VALUE_W-1:0] rsp_voltage_one,
   output logic signed [VALUE_W-1:0] rsp_voltage_two,
   output logic signed [VALUE_W-1:0] rsp_voltage_three,
   output logic signed [VALUE_W-1:0] rsp_temperature_reading
);

   // commands from the sequencer, status back from the datapath
   csfda_cmd_type    cmd;
   csfda_status_type status;

   // sequencer: owns the handshakes and walks the divider through its steps
   csfda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: frame decode, stored readings, running sum, divider, result register
   // the stored readings feed the response directly, since they only change
   // on the transfer that also loads a new result
   csfda_datapath #(
      .COUNT_MAX (COUNT_MAX)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .req_frame_id            (req_frame_id),
      .req_mux_byte            (req_mux_byte),
      .req_value_byte_hi       (req_value_byte_hi),
      .req_value_byte_mid_hi   (req_value_byte_mid_hi),
      .req_value_byte_mid_lo   (req_value_byte_mid_lo),
      .req_value_byte_lo       (req_value_byte_lo),
      .cmd                     (cmd),
      .status                  (status),
      .rsp_frame_accepted      (rsp_frame_accepted),
      .rsp_average_valid       (rsp_average_valid),
      .rsp_average_current     (rsp_average_current),
      .rsp_latest_current      (rsp_latest_current),
      .rsp_voltage_one         (rsp_voltage_one),
      .rsp_voltage_two         (rsp_voltage_two),
      .rsp_voltage_three       (rsp_voltage_three),
      .rsp_temperature_reading (rsp_temperature_reading)
   );

   // a held result blocks new requests
   `CSFDA_ASSERT_IMPLY(a_hold_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // a frame transfer always gives a result on the next cycle
   `CSFDA_ASSERT_NEXT(a_frame_one_cycle, clock, reset, req_valid && req_ready && !req_action, rsp_valid)

   // a poll result never flags an accepted frame
   `CSFDA_ASSERT_IMPLY(a_poll_not_frame, clock, reset, rsp_valid && rsp_average_valid, !rsp_frame_accepted)

   // a frame result carries a zero average
   `CSFDA_ASSERT_IMPLY(a_frame_avg_zero, clock, reset, rsp_valid && !rsp_average_valid, rsp_average_current == '0)

   // no response pending while a poll is being divided
   `CSFDA_ASSERT_IMPLY(a_divide_quiet, clock, reset, cmd.div_step, !rsp_valid && !req_ready)

endmodule
